>>> hw/rtl/midi_led_feedback_dedup_unit_assert.svh
// assertion macros used by the led feedback dedup controller
// plain concurrent properties, clock and active-low reset passed in
`ifndef MIDI_LED_FEEDBACK_DEDUP_UNIT_ASSERT_SVH
`define MIDI_LED_FEEDBACK_DEDUP_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define MLDD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mldd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define MLDD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mldd: next-cycle check failed");

`endif

>>> hw/rtl/mldd_pkg.sv
// shared types, codes and colour shade table for the led feedback dedup unit
// no dependencies
package mldd_pkg;

  localparam int PADS   = 128;
  localparam int PAD_W  = 7;
  localparam int HUES   = 15;
  localparam int SHADES = 3;
  localparam int IDX_W  = 11;

  // request commands
  localparam logic [1:0] CMD_NOTE  = 2'd0;
  localparam logic [1:0] CMD_RING  = 2'd1;
  localparam logic [1:0] CMD_RGB   = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // rgb message sequence
  localparam logic [1:0] MSG_PULSE_OFF = 2'd0;
  localparam logic [1:0] MSG_BLINK_OFF = 2'd1;
  localparam logic [1:0] MSG_PRIMARY   = 2'd2;
  localparam logic [1:0] MSG_ANIM      = 2'd3;

  // midi status bytes
  localparam logic [7:0] STATUS_NOTE      = 8'h90;
  localparam logic [7:0] STATUS_CC        = 8'hB0;
  localparam logic [7:0] STATUS_PULSE_OFF = 8'h98;
  localparam logic [7:0] STATUS_BLINK_OFF = 8'h9D;

  localparam logic [7:0] CACHE_UNKNOWN = 8'hFF;

  localparam logic [6:0] BRIGHT_LOW  = 7'd33;
  localparam logic [6:0] BRIGHT_MID  = 7'd66;
  localparam logic [6:0] BRIGHT_FULL = 7'd100;
  localparam logic [6:0] BRIGHT_RESET = 7'd100;

  localparam logic [6:0] HUE_KEY [HUES] = '{
    7'd5, 7'd9, 7'd11, 7'd13, 7'd14, 7'd15, 7'd21, 7'd20,
    7'd33, 7'd37, 7'd38, 7'd41, 7'd42, 7'd49, 7'd48
  };

  localparam logic [6:0] HUE_SHADE [HUES][SHADES] = '{
    '{7'd7,  7'd6,  7'd5},  '{7'd11, 7'd10, 7'd9},  '{7'd11, 7'd11, 7'd11},
    '{7'd15, 7'd14, 7'd13}, '{7'd15, 7'd14, 7'd14}, '{7'd15, 7'd15, 7'd15},
    '{7'd19, 7'd20, 7'd21}, '{7'd19, 7'd20, 7'd20}, '{7'd35, 7'd34, 7'd33},
    '{7'd39, 7'd38, 7'd37}, '{7'd39, 7'd38, 7'd38}, '{7'd43, 7'd42, 7'd41},
    '{7'd43, 7'd42, 7'd42}, '{7'd47, 7'd48, 7'd49}, '{7'd47, 7'd48, 7'd48}
  };

  typedef struct packed {
    logic       capture;
    logic       load_out;
    logic       wr_cache;
    logic       sweep;
    logic [1:0] msg_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_rgb;
    logic send;
    logic extra;
    logic out_free;
    logic sweep_last;
  } dp_status_t;

  // palette colour scaled by brightness
  function automatic logic [6:0] shade_of(input logic [6:0] color, input logic [6:0] bright);
    logic [1:0] lvl;
    logic [6:0] res;
    lvl = (bright <= BRIGHT_LOW) ? 2'd0 : ((bright <= BRIGHT_MID) ? 2'd1 : 2'd2);
    res = color;
    for (int i = 0; i < HUES; i++) begin
      if (HUE_KEY[i] == color) begin
        res = HUE_SHADE[i][lvl];
      end
    end
    if (color == 7'd0 || bright == 7'd0) begin
      res = 7'd0;
    end else if (bright >= BRIGHT_FULL) begin
      res = color;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/mldd_req_if.sv
// request channel: valid/ready handshake carrying one led feedback request
// no dependencies
interface mldd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [3:0] channel;
  logic [6:0] number;
  logic [6:0] value;
  logic [6:0] second_color;
  logic [3:0] animation;

  modport source (
    output valid, cmd, channel, number, value, second_color, animation,
    input  ready
  );
  modport sink (
    input  valid, cmd, channel, number, value, second_color, animation,
    output ready
  );
endinterface

>>> hw/rtl/mldd_msg_if.sv
// message channel: valid/ready handshake carrying one three-byte midi message
// no dependencies
interface mldd_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] status;
  logic [6:0] data_one;
  logic [6:0] data_two;
  logic       last;

  modport source (
    output valid, status, data_one, data_two, last,
    input  ready
  );
  modport sink (
    input  valid, status, data_one, data_two, last,
    output ready
  );
endinterface

>>> hw/rtl/midi_led_feedback_dedup_unit.sv
// top level of the led feedback dedup unit: controller plus datapath
// depends on mldd_pkg, mldd_req_if, mldd_msg_if, mldd_ctrl and mldd_dp

// Turns led feedback requests into three-byte midi messages and drops any
// request that would not change the pad or, for notes and controllers, is
// out of range. A request reads its cache entry into a register, is compared
// and, once the output register is free, loads its message; an rgb request
// loads its pulse-off, blink-off, primary and, if set, animation messages in
// turn as the register frees. The single output register sets the message
// pace of one per cycle while ready stays high, and can hold the last message
// of one request while the next is taken in. A clear request, and reset,
// clear the caches and pad state over max(CHANNELS*NUMBERS, 128) addresses,
// 2048 at the default sizes, during which no request is taken; brightness
// writes are taken at any time but should land only while the unit is idle.
module midi_led_feedback_dedup_unit #(
  parameter int CHANNELS = 16,
  parameter int NUMBERS  = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  mldd_req_if.sink   req_i,
  mldd_msg_if.source msg_o
);
  import mldd_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;
  logic       in_ready;

  // request transfer happens when the controller sits idle
  assign req_i.ready = in_ready;

  mldd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // caches, pad state, brightness and the message register
  mldd_dp #(
    .CHANNELS (CHANNELS),
    .NUMBERS  (NUMBERS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .req_cmd_i          (req_i.cmd),
    .req_channel_i      (req_i.channel),
    .req_number_i       (req_i.number),
    .req_value_i        (req_i.value),
    .req_second_color_i (req_i.second_color),
    .req_animation_i    (req_i.animation),
    .cmd_i              (ctrl_cmd),
    .status_o           (dp_status),
    .msg_o              (msg_o)
  );

endmodule

>>> hw/rtl/mldd_ctrl.sv
// controller state machine for the led feedback dedup unit
// depends on mldd_pkg and midi_led_feedback_dedup_unit_assert.svh
`include "midi_led_feedback_dedup_unit_assert.svh"

module mldd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mldd_pkg::dp_status_t status_i,
  output mldd_pkg::ctrl_cmd_t  cmd_o
);
  import mldd_pkg::*;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_CHECK = 2'd2;
  localparam logic [1:0] ST_SEND  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [1:0] msg_q, msg_d;

  always_comb begin
    state_d    = state_q;
    msg_d      = msg_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.is_clear) begin
          state_d = ST_SWEEP;
        end else if (!status_i.send) begin
          state_d = ST_IDLE;
        end else if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.wr_cache = 1'b1;
          cmd_o.msg_sel  = MSG_PULSE_OFF;
          if (status_i.is_rgb) begin
            state_d = ST_SEND;
            msg_d   = MSG_BLINK_OFF;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SEND: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          cmd_o.msg_sel  = msg_q;
          msg_d          = 2'(msg_q + 2'd1);
          if (msg_q == MSG_ANIM || (msg_q == MSG_PRIMARY && !status_i.extra)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      msg_q   <= MSG_PULSE_OFF;
    end else begin
      state_q <= state_d;
      msg_q   <= msg_d;
    end
  end

  `MLDD_ASSERT_NEXT(a_accept_to_check, clk_i, rst_ni, state_q == ST_IDLE && in_valid_i, state_q == ST_CHECK)
  `MLDD_ASSERT_NOW(a_load_needs_room, clk_i, rst_ni, cmd_o.load_out, status_i.out_free)
  `MLDD_ASSERT_NOW(a_send_not_first, clk_i, rst_ni, state_q == ST_SEND, msg_q != MSG_PULSE_OFF)
  `MLDD_ASSERT_NOW(a_sweep_blocks_all, clk_i, rst_ni, cmd_o.sweep, !in_ready_o && !cmd_o.load_out)

endmodule

>>> hw/rtl/mldd_dp.sv
// datapath: request capture, caches, pad state memory, shading and message register
// depends on mldd_pkg and mldd_msg_if
module mldd_dp #(
  parameter int CHANNELS = 16,
  parameter int NUMBERS  = 128
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  input  logic [1:0]           req_cmd_i,
  input  logic [3:0]           req_channel_i,
  input  logic [6:0]           req_number_i,
  input  logic [6:0]           req_value_i,
  input  logic [6:0]           req_second_color_i,
  input  logic [3:0]           req_animation_i,
  input  mldd_pkg::ctrl_cmd_t  cmd_i,
  output mldd_pkg::dp_status_t status_o,
  mldd_msg_if.source           msg_o
);
  import mldd_pkg::*;

  localparam int DEPTH = CHANNELS * NUMBERS;
  localparam int CW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SWEEP = (DEPTH > PADS) ? DEPTH : PADS;
  localparam int SW    = $clog2(SWEEP);

  logic [7:0]  note_mem [DEPTH];
  logic [7:0]  ring_mem [DEPTH];
  logic [18:0] pad_mem  [PADS];

  logic [6:0]  bright_q;
  logic [SW-1:0] sweep_q;
  logic        sweep_last;
  logic        sweep_cache, sweep_pad;

  logic [1:0]  cmd_q;
  logic [3:0]  ch_q, anim_q;
  logic [6:0]  num_q, val_q, sec_q;
  logic [CW-1:0] idx_q;
  logic        range_q;
  logic [7:0]  note_rd_q, ring_rd_q;
  logic [18:0] pad_rd_q;

  logic [IDX_W-1:0] idx_full;
  logic        in_range;
  logic [6:0]  prim, secd;
  logic [18:0] pad_word;
  logic        extra, send, out_free;

  logic        out_valid_q;
  logic [7:0]  out_status_q, msg_status;
  logic [6:0]  out_d1_q, out_d2_q, msg_d2;
  logic        out_last_q, msg_last;

  // cache address of the incoming request
  assign idx_full = IDX_W'(req_channel_i) * IDX_W'(NUMBERS) + IDX_W'(req_number_i);
  assign in_range = (5'(req_channel_i) < 5'(CHANNELS)) && (8'(req_number_i) < 8'(NUMBERS));

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= BRIGHT_RESET;
    end else if (cfg_we_i) begin
      bright_q <= cfg_wdata_i;
    end
  end

  // clearing sweep counter
  assign sweep_last  = (sweep_q == SW'(SWEEP - 1));
  assign sweep_cache = ({1'b0, sweep_q} < (SW + 1)'(DEPTH));
  assign sweep_pad   = ({1'b0, sweep_q} < (SW + 1)'(PADS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : SW'(sweep_q + 1'b1);
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q   <= req_cmd_i;
      ch_q    <= req_channel_i;
      num_q   <= req_number_i;
      val_q   <= req_value_i;
      sec_q   <= req_second_color_i;
      anim_q  <= req_animation_i;
      idx_q   <= idx_full[CW-1:0];
      range_q <= in_range;
    end
  end

  // caches and pad state, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      if (sweep_cache) begin
        note_mem[sweep_q[CW-1:0]] <= CACHE_UNKNOWN;
        ring_mem[sweep_q[CW-1:0]] <= CACHE_UNKNOWN;
      end
      if (sweep_pad) begin
        pad_mem[sweep_q[PAD_W-1:0]] <= '0;
      end
    end else if (cmd_i.wr_cache) begin
      case (cmd_q)
        CMD_NOTE: note_mem[idx_q] <= {1'b0, val_q};
        CMD_RING: ring_mem[idx_q] <= {1'b0, val_q};
        CMD_RGB:  pad_mem[num_q]  <= pad_word;
        default: ;
      endcase
    end
    if (cmd_i.capture) begin
      note_rd_q <= note_mem[idx_full[CW-1:0]];
      ring_rd_q <= ring_mem[idx_full[CW-1:0]];
      pad_rd_q  <= pad_mem[req_number_i];
    end
  end

  // shading and change detection
  assign prim     = shade_of(val_q, bright_q);
  assign secd     = shade_of(sec_q, bright_q);
  assign pad_word = {1'b1, prim, secd, anim_q};
  assign extra    = (anim_q != 4'd0) && (secd != 7'd0);

  always_comb begin
    case (cmd_q)
      CMD_NOTE: send = range_q && (note_rd_q != {1'b0, val_q});
      CMD_RING: send = range_q && (ring_rd_q != {1'b0, val_q});
      CMD_RGB:  send = (pad_rd_q != pad_word);
      default:  send = 1'b0;
    endcase
  end

  // message formation
  always_comb begin
    msg_status = STATUS_NOTE | {4'h0, ch_q};
    msg_d2     = val_q;
    msg_last   = 1'b1;
    if (cmd_q == CMD_RGB) begin
      case (cmd_i.msg_sel)
        MSG_PULSE_OFF: begin
          msg_status = STATUS_PULSE_OFF;
          msg_d2     = 7'd0;
          msg_last   = 1'b0;
        end
        MSG_BLINK_OFF: begin
          msg_status = STATUS_BLINK_OFF;
          msg_d2     = 7'd0;
          msg_last   = 1'b0;
        end
        MSG_PRIMARY: begin
          msg_status = STATUS_NOTE;
          msg_d2     = prim;
          msg_last   = !extra;
        end
        MSG_ANIM: begin
          msg_status = STATUS_NOTE | {4'h0, anim_q};
          msg_d2     = secd;
          msg_last   = 1'b1;
        end
        default: begin
          msg_status = STATUS_NOTE;
        end
      endcase
    end else if (cmd_q == CMD_RING) begin
      msg_status = STATUS_CC | {4'h0, ch_q};
    end
  end

  // output register
  assign out_free = !out_valid_q || msg_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (msg_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= msg_status;
      out_d1_q     <= num_q;
      out_d2_q     <= msg_d2;
      out_last_q   <= msg_last;
    end
  end

  assign msg_o.valid    = out_valid_q;
  assign msg_o.status   = out_status_q;
  assign msg_o.data_one = out_d1_q;
  assign msg_o.data_two = out_d2_q;
  assign msg_o.last     = out_last_q;

  assign status_o.is_clear   = (cmd_q == CMD_CLEAR);
  assign status_o.is_rgb     = (cmd_q == CMD_RGB);
  assign status_o.send       = send;
  assign status_o.extra      = extra;
  assign status_o.out_free   = out_free;
  assign status_o.sweep_last = sweep_last;

endmodule
